/* sv/dqo_pkg.sv */
`default_nettype none

package dqo_pkg;

	localparam int OUT_W = 32;
	localparam int K_W = 20;
	// magnitude word holds the widest count sum, split in two halves for the multipliers
	localparam int MAG_W = 66;
	localparam int HALF_W = MAG_W / 2;
	localparam int PROD_W = HALF_W + K_W;
	localparam int FULL_W = MAG_W + K_W;

	localparam logic [K_W-1:0] MM_PER_TICK_RST = K_W'(5571);
	localparam logic [K_W-1:0] DEG_PER_COUNT_RST = K_W'(15729);

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_SNAPSHOT = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_MM_PER_TICK = 1'b0,
		CFG_DEG_PER_COUNT = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		cmd_t cmd;
		logic right_a;
		logic right_b;
		logic left_a;
		logic left_b;
	} item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] right_position;
		logic signed [OUT_W-1:0] left_position;
		logic signed [OUT_W-1:0] right_step;
		logic signed [OUT_W-1:0] left_step;
		logic signed [OUT_W-1:0] travel_mm;
		logic signed [OUT_W-1:0] heading_deg;
		logic signed [OUT_W-1:0] skew;
	} result_t;

	// live fields carried down the pipeline beside the odometry arithmetic
	typedef struct packed {
		cmd_t kind;
		logic [OUT_W-1:0] right_pos;
		logic [OUT_W-1:0] left_pos;
		logic [OUT_W-1:0] right_diff;
		logic [OUT_W-1:0] left_diff;
		logic [OUT_W-1:0] skew;
	} live_t;

	typedef struct packed {
		logic ld_s2;
		logic ld_s3;
		logic ld_s4;
	} adv_t;

endpackage

`default_nettype wire

/* sv/dqo_wheel.sv */
`default_nettype none

module dqo_wheel #(
	parameter int CNT_W = 32,
	parameter bit INVERT = 1'b0
) (
	input  wire logic [CNT_W-1:0] count,
	input  wire logic             a,
	input  wire logic             b,
	input  wire logic             a_prev,
	input  wire logic             b_prev,
	output logic      [CNT_W-1:0] count_next
);

	logic up_a;
	logic up_b;
	logic [CNT_W-1:0] inc_a;
	logic [CNT_W-1:0] inc_b;

	// B is judged against the new A, so a double change takes A first
	assign up_a = (a != b_prev) ^ INVERT;
	assign up_b = (a == b) ^ INVERT;

	always_comb begin
		inc_a = '0;
		inc_b = '0;
		if (a != a_prev) begin
			inc_a = up_a ? CNT_W'(1) : '1;
		end
		if (b != b_prev) begin
			inc_b = up_b ? CNT_W'(1) : '1;
		end
		count_next = count + inc_a + inc_b;
	end

endmodule

`default_nettype wire

/* sv/dqo_scale.sv */
`default_nettype none

module dqo_scale #(
	parameter int SUM_W = 33,
	parameter int SHIFT = 17
) (
	input  wire logic                           clk,
	input  wire dqo_pkg::adv_t                  adv,
	input  wire logic signed [SUM_W-1:0]        sum,
	input  wire logic [dqo_pkg::K_W-1:0]        k,
	output logic signed [dqo_pkg::OUT_W-1:0]    res
);

	localparam int MAG_W = dqo_pkg::MAG_W;
	localparam int HALF_W = dqo_pkg::HALF_W;
	localparam int PROD_W = dqo_pkg::PROD_W;
	localparam int FULL_W = dqo_pkg::FULL_W;
	localparam int OUT_W = dqo_pkg::OUT_W;

	logic signed [MAG_W-1:0] ext;
	logic [MAG_W-1:0] mag;

	logic [MAG_W-1:0] mag_s2;
	logic neg_s2;
	logic [PROD_W-1:0] plo_s3;
	logic [PROD_W-1:0] phi_s3;
	logic neg_s3;
	logic [FULL_W-1:0] full_s4;
	logic neg_s4;

	logic [FULL_W-1:0] quo;
	logic [FULL_W-1:0] lim;
	logic [FULL_W-1:0] clip;

	assign ext = MAG_W'(sum);
	assign mag = ext[MAG_W-1] ? MAG_W'(-ext) : MAG_W'(ext);

	always_ff @(posedge clk) begin
		if (adv.ld_s2) begin
			mag_s2 <= mag;
			neg_s2 <= ext[MAG_W-1];
		end
		if (adv.ld_s3) begin
			plo_s3 <= PROD_W'(mag_s2[HALF_W-1:0]) * PROD_W'(k);
			phi_s3 <= PROD_W'(mag_s2[MAG_W-1:HALF_W]) * PROD_W'(k);
			neg_s3 <= neg_s2;
		end
		if (adv.ld_s4) begin
			full_s4 <= (FULL_W'(phi_s3) << HALF_W) + FULL_W'(plo_s3);
			neg_s4 <= neg_s3;
		end
	end

	// truncate the magnitude, clip to the signed range, then restore the sign
	always_comb begin
		quo = full_s4 >> SHIFT;
		lim = neg_s4 ? (FULL_W'(1) << (OUT_W - 1)) : ((FULL_W'(1) << (OUT_W - 1)) - FULL_W'(1));
		clip = (quo > lim) ? lim : quo;
		res = neg_s4 ? $signed(-clip[OUT_W-1:0]) : $signed(clip[OUT_W-1:0]);
	end

endmodule

`default_nettype wire

/* sv/dual_quadrature_odometry.sv */
// Dual quadrature odometry: two x4 wheel decoders and a snapshot odometry unit.
// Items enter on item / item_valid / item_stall; cmd selects a pin sample, a
// snapshot (latch both counts, their change since the previous snapshot, and
// compute travel and heading) or a clear of all counting state.
// Every item gives exactly one result on result / result_valid / result_stall,
// showing the state after that item's command.
// Throughput: one item per cycle while result_stall is low. The odometry path
// runs through the sum register (loaded on acceptance), the magnitude, two
// 33x20 partial products, the final wide add, then clip and sign to result.
// Wheel counts update on the cycle of acceptance, so pin samples on
// consecutive cycles never miss an edge.
// A held result (result_stall high) stops only the output register; the four
// inner stages keep filling, and item_stall rises once all of them are full.
// cfg_valid/cfg_ready writes mm_per_tick (index 0) or deg_per_count (index 1);
// cfg_ready is always high. Write configuration only while the block is empty.
// Reset clears all counts, latched values, travel, heading and line levels, and
// restores both scale registers to their defaults. Clear keeps the registers.
`default_nettype none

module dual_quadrature_odometry #(
	parameter int COUNT_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       item_valid,
	output logic                            item_stall,
	input  wire dqo_pkg::item_t             item,
	output logic                            result_valid,
	input  wire logic                       result_stall,
	output dqo_pkg::result_t                result,
	input  wire logic                       cfg_valid,
	output logic                            cfg_ready,
	input  wire dqo_pkg::cfg_idx_t          cfg_index,
	input  wire logic [dqo_pkg::K_W-1:0]    cfg_data
);

	localparam int CW = COUNT_WIDTH;
	localparam int SUM_W = COUNT_WIDTH + 1;
	localparam int OUT_W = dqo_pkg::OUT_W;

	logic [dqo_pkg::K_W-1:0] mm_q;
	logic [dqo_pkg::K_W-1:0] deg_q;

	logic [3:0] levels_q;
	logic [CW-1:0] right_q;
	logic [CW-1:0] left_q;
	logic [CW-1:0] right_lat_q;
	logic [CW-1:0] left_lat_q;
	logic [CW-1:0] right_diff_q;
	logic [CW-1:0] left_diff_q;
	logic signed [OUT_W-1:0] dist_q;
	logic signed [OUT_W-1:0] angle_q;

	logic [3:0] levels_d;
	logic [CW-1:0] right_d;
	logic [CW-1:0] left_d;
	logic [CW-1:0] right_lat_d;
	logic [CW-1:0] left_lat_d;
	logic [CW-1:0] right_diff_d;
	logic [CW-1:0] left_diff_d;
	logic [CW-1:0] right_sample;
	logic [CW-1:0] left_sample;

	logic v1_q;
	logic v2_q;
	logic v3_q;
	logic v4_q;
	logic out_valid_q;
	logic go1;
	logic go2;
	logic go3;
	logic go4;
	logic go_out;
	logic accept;
	dqo_pkg::adv_t adv;

	dqo_pkg::live_t live_s1;
	dqo_pkg::live_t live_s2;
	dqo_pkg::live_t live_s3;
	dqo_pkg::live_t live_s4;
	logic signed [SUM_W-1:0] sum_s1;
	logic signed [SUM_W-1:0] dif_s1;

	logic signed [OUT_W-1:0] dist_res;
	logic signed [OUT_W-1:0] angle_res;
	logic signed [OUT_W-1:0] dist_d;
	logic signed [OUT_W-1:0] angle_d;
	dqo_pkg::result_t result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mm_q <= dqo_pkg::MM_PER_TICK_RST;
			deg_q <= dqo_pkg::DEG_PER_COUNT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				dqo_pkg::CFG_MM_PER_TICK: mm_q <= cfg_data;
				dqo_pkg::CFG_DEG_PER_COUNT: deg_q <= cfg_data;
			endcase
		end
	end

	// handshake: each stage loads when empty or when the one after it moves on
	assign go_out = !out_valid_q || !result_stall;
	assign go4 = !v4_q || go_out;
	assign go3 = !v3_q || go4;
	assign go2 = !v2_q || go3;
	assign go1 = !v1_q || go2;
	assign item_stall = !go1;
	assign accept = item_valid && go1;
	assign adv.ld_s2 = go2 && v1_q;
	assign adv.ld_s3 = go3 && v2_q;
	assign adv.ld_s4 = go4 && v3_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (go1) v1_q <= item_valid;
			if (go2) v2_q <= v1_q;
			if (go3) v3_q <= v2_q;
			if (go4) v4_q <= v3_q;
			if (go_out) out_valid_q <= v4_q;
		end
	end

	dqo_wheel #(
		.CNT_W(CW),
		.INVERT(1'b0)
	) u_right (
		.count(right_q),
		.a(item.right_a),
		.b(item.right_b),
		.a_prev(levels_q[0]),
		.b_prev(levels_q[1]),
		.count_next(right_sample)
	);

	dqo_wheel #(
		.CNT_W(CW),
		.INVERT(1'b1)
	) u_left (
		.count(left_q),
		.a(item.left_a),
		.b(item.left_b),
		.a_prev(levels_q[2]),
		.b_prev(levels_q[3]),
		.count_next(left_sample)
	);

	always_comb begin
		levels_d = levels_q;
		right_d = right_q;
		left_d = left_q;
		right_lat_d = right_lat_q;
		left_lat_d = left_lat_q;
		right_diff_d = right_diff_q;
		left_diff_d = left_diff_q;
		case (item.cmd)
			dqo_pkg::CMD_SAMPLE: begin
				right_d = right_sample;
				left_d = left_sample;
				levels_d = {item.left_b, item.left_a, item.right_b, item.right_a};
			end
			dqo_pkg::CMD_SNAPSHOT: begin
				right_diff_d = right_q - right_lat_q;
				left_diff_d = left_q - left_lat_q;
				right_lat_d = right_q;
				left_lat_d = left_q;
			end
			dqo_pkg::CMD_CLEAR: begin
				levels_d = '0;
				right_d = '0;
				left_d = '0;
				right_lat_d = '0;
				left_lat_d = '0;
				right_diff_d = '0;
				left_diff_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			levels_q <= '0;
			right_q <= '0;
			left_q <= '0;
			right_lat_q <= '0;
			left_lat_q <= '0;
			right_diff_q <= '0;
			left_diff_q <= '0;
		end else if (accept) begin
			levels_q <= levels_d;
			right_q <= right_d;
			left_q <= left_d;
			right_lat_q <= right_lat_d;
			left_lat_q <= left_lat_d;
			right_diff_q <= right_diff_d;
			left_diff_q <= left_diff_d;
		end
	end

	// counts are zero-extended into the 32-bit result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			live_s1.kind <= item.cmd;
			live_s1.right_pos <= OUT_W'(right_d);
			live_s1.left_pos <= OUT_W'(left_d);
			live_s1.right_diff <= OUT_W'(right_diff_d);
			live_s1.left_diff <= OUT_W'(left_diff_d);
			live_s1.skew <= OUT_W'(left_d) - OUT_W'(right_d);
			sum_s1 <= SUM_W'($signed(right_q)) + SUM_W'($signed(left_q));
			dif_s1 <= SUM_W'($signed(right_q)) - SUM_W'($signed(left_q));
		end
		if (adv.ld_s2) live_s2 <= live_s1;
		if (adv.ld_s3) live_s3 <= live_s2;
		if (adv.ld_s4) live_s4 <= live_s3;
	end

	dqo_scale #(
		.SUM_W(SUM_W),
		.SHIFT(FRAC_BITS + 1)
	) u_travel (
		.clk(clk),
		.adv(adv),
		.sum(sum_s1),
		.k(mm_q),
		.res(dist_res)
	);

	dqo_scale #(
		.SUM_W(SUM_W),
		.SHIFT(FRAC_BITS + 2)
	) u_heading (
		.clk(clk),
		.adv(adv),
		.sum(dif_s1),
		.k(deg_q),
		.res(angle_res)
	);

	always_comb begin
		dist_d = dist_q;
		angle_d = angle_q;
		case (live_s4.kind)
			dqo_pkg::CMD_SNAPSHOT: begin
				dist_d = dist_res;
				angle_d = angle_res;
			end
			dqo_pkg::CMD_CLEAR: begin
				dist_d = '0;
				angle_d = '0;
			end
			default: begin
			end
		endcase
	end

	// odometry results are held here in item order, updated as items leave
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			angle_q <= '0;
		end else if (go_out && v4_q) begin
			dist_q <= dist_d;
			angle_q <= angle_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go_out && v4_q) begin
			result_q.right_position <= $signed(live_s4.right_pos);
			result_q.left_position <= $signed(live_s4.left_pos);
			result_q.right_step <= $signed(live_s4.right_diff);
			result_q.left_step <= $signed(live_s4.left_diff);
			result_q.travel_mm <= dist_d;
			result_q.heading_deg <= angle_d;
			result_q.skew <= $signed(live_s4.skew);
		end
	end

	assign result = result_q;
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire
